// ===== src/ctr_pkg.sv =====
// shared constants, coefficient matrix and types for the chromaticity to rgb converter
package ctr_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int XW = 16;
	localparam int BW = 17;
	localparam int LW = 8;
	localparam int QW = LW + 1;

	localparam logic [BW-1:0] ONE_COORD = BW'(64'd1 << COORD_FRAC_BITS);

	localparam int CW = 26;
	localparam int ZW = XW + 1;
	localparam int PW = CW + ZW + 1;
	localparam int NW = PW + 2;
	localparam int POSW = NW - 1;
	localparam int HW = (POSW + 1) / 2;
	localparam int PROW = POSW + BW;

	localparam int SCW = 24;
	localparam logic [SCW-1:0] COEF_SCALE = 24'd10000000;
	localparam int YMW = XW + SCW;
	localparam int KW = YMW + COORD_FRAC_BITS;

	localparam int TOLW = 7;
	localparam logic [TOLW-1:0] GAMUT_TOL = 7'd100;
	localparam int TYW = XW + TOLW;

	localparam int DW = ((KW > POSW) ? KW : POSW) + 1;
	localparam int STEPS = 2 * LW;

	localparam logic signed [CW-1:0] MAT [3][3] = '{
		'{ 26'sd32404542, -26'sd15371385, -26'sd4985314},
		'{-26'sd9692660,   26'sd18760108,  26'sd415560},
		'{ 26'sd556434,   -26'sd2040259,   26'sd10572252}
	};

	typedef struct packed {
		logic [DW-1:0] num;
		logic [DW-1:0] den;
		logic [DW-1:0] r;
		logic [QW-1:0] q;
	} lane_t;

	typedef lane_t [2:0] lane3_t;

	typedef struct packed {
		logic valid;
		logic bad;
	} tag_t;

endpackage

// ===== src/ctr_in_if.sv =====
// input channel: chromaticity and brightness word
interface ctr_in_if;
	import ctr_pkg::*;
	logic valid;
	logic ready;
	logic [XW-1:0] chroma_x;
	logic [XW-1:0] chroma_y;
	logic [BW-1:0] brightness;
	modport source(output valid, output chroma_x, output chroma_y, output brightness,
		input ready);
	modport sink(input valid, input chroma_x, input chroma_y, input brightness,
		output ready);
endinterface

// ===== src/ctr_out_if.sv =====
// output channel: three pwm levels and status word
interface ctr_out_if;
	import ctr_pkg::*;
	logic valid;
	logic ready;
	logic [LW-1:0] red_level;
	logic [LW-1:0] green_level;
	logic [LW-1:0] blue_level;
	logic status;
	modport source(output valid, output red_level, output green_level, output blue_level,
		output status, input ready);
	modport sink(input valid, input red_level, input green_level, input blue_level,
		input status, output ready);
endinterface

// ===== src/ctr_matrix.sv =====
// argument checks, xyz expansion and inverse matrix, two stages
module ctr_matrix import ctr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [XW-1:0]       chroma_x,
	input  logic [XW-1:0]       chroma_y,
	input  logic [BW-1:0]       brightness,
	output tag_t                tag,
	output logic [POSW-1:0]     pos [3],
	output logic [KW-1:0]       k,
	output logic [BW-1:0]       bright
);
	logic                   valid_s1, valid_s2;
	logic                   bad_s1, bad_s2;
	logic signed [PW-1:0]   prod_s1 [3][3];
	logic [TYW-1:0]         ty_s1;
	logic [YMW-1:0]         ymul_s1;
	logic [BW-1:0]          b_s1, b_s2;
	logic [POSW-1:0]        pos_s2 [3];
	logic [KW-1:0]          k_s2;

	logic [ZW-1:0]          xy_sum;
	logic [ZW-1:0]          z;
	logic                   bad_in;
	logic signed [NW-1:0]   n [3];
	logic signed [NW-1:0]   neg_ty;
	logic [2:0]             gamut;

	assign xy_sum = {1'b0, chroma_x} + {1'b0, chroma_y};
	assign z = ZW'(ONE_COORD) - xy_sum;
	assign bad_in = (chroma_y == '0) || (xy_sum > ZW'(ONE_COORD)) || (brightness > ONE_COORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i][0] <= PW'(MAT[i][0]) * PW'($signed({2'b00, chroma_x}));
				prod_s1[i][1] <= PW'(MAT[i][1]) * PW'($signed({2'b00, chroma_y}));
				prod_s1[i][2] <= PW'(MAT[i][2]) * PW'($signed({1'b0, z}));
			end
			ty_s1 <= TYW'(chroma_y) * TYW'(GAMUT_TOL);
			ymul_s1 <= YMW'(chroma_y) * YMW'(COEF_SCALE);
			bad_s1 <= bad_in;
			b_s1 <= brightness;
		end
	end

	assign neg_ty = -$signed({{(NW-TYW){1'b0}}, ty_s1});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n[i] = NW'(prod_s1[i][0]) + NW'(prod_s1[i][1]) + NW'(prod_s1[i][2]);
			gamut[i] = n[i] < neg_ty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pos_s2[i] <= n[i][NW-1] ? '0 : n[i][POSW-1:0];
			k_s2 <= {ymul_s1, {COORD_FRAC_BITS{1'b0}}};
			bad_s2 <= bad_s1 || (|gamut);
			b_s2 <= b_s1;
		end
	end

	assign tag = '{valid: valid_s2, bad: bad_s2};
	assign pos = pos_s2;
	assign k = k_s2;
	assign bright = b_s2;
endmodule

// ===== src/ctr_norm.sv =====
// brightness scaling, peak search and choice of divider operands, four stages
module ctr_norm import ctr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tag_t                tag_in,
	input  logic [POSW-1:0]     pos [3],
	input  logic [KW-1:0]       k,
	input  logic [BW-1:0]       bright,
	output tag_t                tag_out,
	output lane3_t              lanes
);
	logic                   valid_s3, valid_s4, valid_s5, valid_s6;
	logic                   bad_s3, bad_s4, bad_s5, bad_s6;
	logic [POSW-HW+BW-1:0]  ph_s3 [3];
	logic [HW+BW-1:0]       pl_s3 [3];
	logic [POSW-1:0]        pos_s3 [3], pos_s4 [3], pos_s5 [3];
	logic [KW-1:0]          k_s3, k_s4, k_s5;
	logic [PROW-1:0]        p_s4 [3], p_s5 [3];
	logic [PROW-1:0]        pmax_s5;
	logic [POSW-1:0]        nmax_s5;
	lane3_t                 lanes_s6;

	logic [PROW-1:0]        pm01;
	logic [POSW-1:0]        nm01;
	logic                   big;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s3 <= tag_in.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign pm01 = (p_s4[0] > p_s4[1]) ? p_s4[0] : p_s4[1];
	assign nm01 = (pos_s4[0] > pos_s4[1]) ? pos_s4[0] : pos_s4[1];
	assign big = pmax_s5 > PROW'(k_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ph_s3[i] <= (POSW-HW+BW)'(pos[i][POSW-1:HW]) * (POSW-HW+BW)'(bright);
				pl_s3[i] <= (HW+BW)'(pos[i][HW-1:0]) * (HW+BW)'(bright);
			end
			pos_s3 <= pos;
			k_s3 <= k;
			bad_s3 <= tag_in.bad;

			for (int i = 0; i < 3; i++)
				p_s4[i] <= (PROW'(ph_s3[i]) << HW) + PROW'(pl_s3[i]);
			pos_s4 <= pos_s3;
			k_s4 <= k_s3;
			bad_s4 <= bad_s3;

			// the largest scaled channel belongs to the largest raw channel
			pmax_s5 <= (pm01 > p_s4[2]) ? pm01 : p_s4[2];
			nmax_s5 <= (nm01 > pos_s4[2]) ? nm01 : pos_s4[2];
			p_s5 <= p_s4;
			pos_s5 <= pos_s4;
			k_s5 <= k_s4;
			bad_s5 <= bad_s4;

			for (int i = 0; i < 3; i++) begin
				if (big) begin
					lanes_s6[i].num <= DW'(pos_s5[i]);
					lanes_s6[i].den <= DW'(nmax_s5);
				end else begin
					lanes_s6[i].num <= DW'(p_s5[i][KW-1:0]);
					lanes_s6[i].den <= DW'(k_s5);
				end
				lanes_s6[i].r <= '0;
				lanes_s6[i].q <= '0;
			end
			bad_s6 <= bad_s5;
		end
	end

	assign tag_out = '{valid: valid_s6, bad: bad_s6};
	assign lanes = lanes_s6;
endmodule

// ===== src/ctr_div.sv =====
// restoring 255*num/den divider, one compare-subtract per stage, then rounding
module ctr_div import ctr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tag_t                tag_in,
	input  lane3_t              lanes_in,
	output logic                out_valid,
	output logic [LW-1:0]       red_level,
	output logic [LW-1:0]       green_level,
	output logic [LW-1:0]       blue_level,
	output logic                status
);
	lane3_t                 lanes_s [STEPS];
	logic                   valid_s [STEPS];
	logic                   bad_s [STEPS];
	logic                   valid_s23;
	logic                   status_s23;
	logic [LW-1:0]          level_s23 [3];

	logic [QW-1:0]          qf [3];

	// doubling half of one quotient bit
	function automatic lane_t step_a(input lane_t l);
		lane_t o;
		logic [DW-1:0] d;
		o = l;
		d = l.den - l.r;
		if (l.r >= d) begin
			o.r = l.r - d;
			o.q = {l.q[QW-2:0], 1'b1};
		end else begin
			o.r = {l.r[DW-2:0], 1'b0};
			o.q = {l.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	// adding half: r + num against den
	function automatic lane_t step_b(input lane_t l);
		lane_t o;
		logic [DW-1:0] d;
		o = l;
		d = l.den - l.num;
		if (l.r >= d) begin
			o.r = l.r - d;
			o.q = l.q + QW'(1);
		end else begin
			o.r = l.r + l.num;
		end
		return o;
	endfunction

	for (genvar s = 0; s < STEPS; s++) begin : g_step
		lane3_t prev;
		logic   prev_valid;
		logic   prev_bad;
		if (s == 0) begin : g_first
			assign prev = lanes_in;
			assign prev_valid = tag_in.valid;
			assign prev_bad = tag_in.bad;
		end else begin : g_next
			assign prev = lanes_s[s-1];
			assign prev_valid = valid_s[s-1];
			assign prev_bad = bad_s[s-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[s] <= 1'b0;
			else if (en)
				valid_s[s] <= prev_valid;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++)
					lanes_s[s][i] <= ((s % 2) == 0) ? step_a(prev[i]) : step_b(prev[i]);
				bad_s[s] <= prev_bad;
			end
		end
	end

	// round half up on the last remainder, then saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qf[i] = lanes_s[STEPS-1][i].q;
			if (lanes_s[STEPS-1][i].r >= lanes_s[STEPS-1][i].den - lanes_s[STEPS-1][i].r)
				qf[i] = qf[i] + QW'(1);
			if (qf[i][QW-1])
				qf[i] = {1'b0, {LW{1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s23 <= 1'b0;
		else if (en)
			valid_s23 <= valid_s[STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				level_s23[i] <= bad_s[STEPS-1] ? '0 : qf[i][LW-1:0];
			status_s23 <= bad_s[STEPS-1];
		end
	end

	assign out_valid = valid_s23;
	assign red_level = level_s23[0];
	assign green_level = level_s23[1];
	assign blue_level = level_s23[2];
	assign status = status_s23;
endmodule

// ===== src/chromaticity_to_rgb_pwm_top.sv =====
// top level of the cie xy to linear rgb pwm level converter
// Converts a CIE xy chromaticity and a brightness into three 8-bit linear PWM levels
// for sRGB/D65 primaries, with status 1 (and zero levels) for an invalid argument or a
// color outside the gamut. The pipeline takes one word every cycle unless the output
// stalls. Two stages form the matrix product, four scale by brightness and pick the
// divider operands, sixteen stages of compare-subtract build the eight quotient bits
// and one stage rounds. A stall at the output freezes the whole pipeline, so input
// ready follows output ready whenever the output register is full.
module chromaticity_to_rgb_pwm_top import ctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ctr_in_if.sink      pix_in,
	ctr_out_if.source   pix_out
);
	logic               en;
	logic               out_valid;
	tag_t               tag_m, tag_n;
	logic [POSW-1:0]    pos [3];
	logic [KW-1:0]      k;
	logic [BW-1:0]      bright;
	lane3_t             lanes;

	assign en = !out_valid || pix_out.ready;
	assign pix_in.ready = en;

	ctr_matrix u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (pix_in.valid),
		.chroma_x   (pix_in.chroma_x),
		.chroma_y   (pix_in.chroma_y),
		.brightness (pix_in.brightness),
		.tag        (tag_m),
		.pos        (pos),
		.k          (k),
		.bright     (bright)
	);

	ctr_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_m),
		.pos     (pos),
		.k       (k),
		.bright  (bright),
		.tag_out (tag_n),
		.lanes   (lanes)
	);

	ctr_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.tag_in      (tag_n),
		.lanes_in    (lanes),
		.out_valid   (out_valid),
		.red_level   (pix_out.red_level),
		.green_level (pix_out.green_level),
		.blue_level  (pix_out.blue_level),
		.status      (pix_out.status)
	);

	assign pix_out.valid = out_valid;

`ifndef SYNTH
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.status) |->
		(pix_out.red_level == '0 && pix_out.green_level == '0 && pix_out.blue_level == '0))
		else $error("failed word carries nonzero levels");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_out.valid |-> pix_in.ready)
		else $error("input blocked while output register empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready) |=> (!pix_in.ready || pix_out.ready))
		else $error("input taken during output stall");
`endif
endmodule
